// ===== sv/tediv_pkg.sv =====
// ----------------------------------------------------------------------------
// tediv_pkg
// shared types and codes for the time expansion and frequency divider block
// ----------------------------------------------------------------------------
package tediv_pkg;

    localparam int SAMPLE_W = 16;
    localparam int CLEN_W   = 15;
    localparam int RATIO_W  = 8;
    localparam int MODE_W   = 2;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    // operating modes
    localparam logic [MODE_W-1:0] MODE_PASS    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_EXPAND  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DIVIDE  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE        = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAPTURE_LEN = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STRETCH     = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIVIDE      = 8'd3;

    // register reset values
    localparam logic [MODE_W-1:0]  MODE_RST        = MODE_PASS;
    localparam logic [CLEN_W-1:0]  CAPTURE_LEN_RST = 15'd16384;
    localparam logic [RATIO_W-1:0] STRETCH_RST     = 8'd10;
    localparam logic [RATIO_W-1:0] DIVIDE_RST      = 8'd10;

    // word waiting on the bank read
    typedef struct packed {
        logic                use_bank;
        logic [SAMPLE_W-1:0] direct;
        logic                playing;
    } stage_t;

endpackage

// ===== sv/tediv_ram.sv =====
// ----------------------------------------------------------------------------
// tediv_ram
// simple dual port ram, one write port, one read port with registered data
// ----------------------------------------------------------------------------
module tediv_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16384
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sv/time_expansion_and_divider_top.sv =====
// ----------------------------------------------------------------------------
// time_expansion_and_divider_top
// bat detector audio effect: passthrough, time expansion and sample-hold divider
// ----------------------------------------------------------------------------
//
//  channel   ports                                   direction
//  s_        s_valid s_ready s_sample_in             in
//            s_capture_request
//  m_        m_valid m_ready m_sample_out m_playing  out
//  cfg_      cfg_valid cfg_ready cfg_index cfg_data  in, always ready
//
// one word accepted per cycle unless the output stalls; each word is registered
// in stage one, beside the registered bank read, then in the output register
// reset is synchronous; no clearing pass: a fill mark tracks how far the bank
// has been written since reset, and reads beyond it return zero
// a stalled output holds the pipeline; the bank read is only enabled on accept
// so its data stays put while the word waits
//
module time_expansion_and_divider_top
    import tediv_pkg::*;
#(
    parameter int BANK_DEPTH = 16384
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [SAMPLE_W-1:0]   s_sample_in,
    input  logic                  s_capture_request,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [SAMPLE_W-1:0]   m_sample_out,
    output logic                  m_playing,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // position width holds 0..BANK_DEPTH, address width indexes the bank
    localparam int PW = $clog2(BANK_DEPTH + 1);
    localparam int AW = $clog2(BANK_DEPTH);
    localparam int CW = (PW > CLEN_W) ? PW : CLEN_W;
    localparam logic [PW-1:0] DEPTH_P = PW'(BANK_DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(BANK_DEPTH);

    // configuration registers
    logic [MODE_W-1:0]  mode_reg;
    logic [CLEN_W-1:0]  capture_len_reg;
    logic [RATIO_W-1:0] stretch_reg;
    logic [RATIO_W-1:0] divide_reg;

    // effect state
    logic [PW-1:0]       write_pos_reg, write_pos_next;
    logic [PW-1:0]       read_pos_reg, read_pos_next;
    logic [RATIO_W-1:0]  stretch_count_reg, stretch_count_next;
    logic                recording_reg, recording_next;
    logic                play_reg, play_next;
    logic [RATIO_W-1:0]  hold_count_reg, hold_count_next;
    logic [SAMPLE_W-1:0] held_reg, held_next;
    logic [PW-1:0]       fill_reg, fill_next;   // bank written below this mark

    // pipeline
    logic                p1_valid_reg;
    stage_t              p1_reg, p1_next;
    logic                m_valid_reg;
    logic [SAMPLE_W-1:0] m_sample_reg;
    logic                m_playing_reg;

    logic                s_accept;
    logic                advance;

    // bank ports
    logic                bank_we;
    logic [AW-1:0]       bank_waddr;
    logic [AW-1:0]       bank_raddr;
    logic [SAMPLE_W-1:0] bank_rdata;

    assign advance   = !m_valid_reg || m_ready;
    assign s_ready   = !p1_valid_reg || advance;
    assign s_accept  = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= MODE_RST;
            capture_len_reg <= CAPTURE_LEN_RST;
            stretch_reg     <= STRETCH_RST;
            divide_reg      <= DIVIDE_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_MODE:        mode_reg        <= cfg_data[MODE_W-1:0];
                REG_CAPTURE_LEN: capture_len_reg <= cfg_data[CLEN_W-1:0];
                REG_STRETCH:     stretch_reg     <= cfg_data[RATIO_W-1:0];
                REG_DIVIDE:      divide_reg      <= cfg_data[RATIO_W-1:0];
                default: ;
            endcase
        end
    end

    // per-word state update and bank access
    always_comb begin
        logic [CW-1:0]      cap_ext;
        logic [PW-1:0]      len;
        logic               rec0;
        logic [PW-1:0]      wp0, rp0, wpw, wp1, rp1, fill_new;
        logic [RATIO_W-1:0] sc0, sc1, sc2, hc0;
        logic               play1, wr;

        cap_ext = CW'(capture_len_reg);
        if (cap_ext > DEPTH_C) begin
            len = DEPTH_P;
        end else if (cap_ext == '0) begin
            len = PW'(1);
        end else begin
            len = PW'(cap_ext);
        end

        // capture request restarts the bank
        rec0 = s_capture_request || recording_reg;
        wp0  = s_capture_request ? '0 : write_pos_reg;
        rp0  = s_capture_request ? '0 : read_pos_reg;
        sc0  = s_capture_request ? '0 : stretch_count_reg;

        // recording: the last slot of a full bank is written once more
        wr             = rec0;
        wpw            = wp0;
        recording_next = rec0;
        if (rec0 && (wp0 >= len)) begin
            wpw            = len - PW'(1);
            recording_next = 1'b0;
        end
        wp1   = rec0 ? (wpw + PW'(1)) : wp0;
        play1 = rec0 ? 1'b1 : play_reg;

        // playback advance every stretch_factor words
        sc1 = sc0 + RATIO_W'(1);
        rp1 = rp0;
        sc2 = sc0;
        if (play1) begin
            if (sc1 == stretch_reg) begin
                rp1 = rp0 + PW'(1);
                sc2 = '0;
            end else begin
                sc2 = sc1;
            end
        end

        fill_new = (wr && ((wpw + PW'(1)) > fill_reg)) ? (wpw + PW'(1)) : fill_reg;

        // end of playback
        write_pos_next     = wp1;
        read_pos_next      = rp1;
        stretch_count_next = sc2;
        play_next          = play1;
        if (rp1 >= wp1) begin
            read_pos_next      = '0;
            stretch_count_next = '0;
            play_next          = 1'b0;
        end

        // divider: sample and hold
        hc0       = hold_count_reg;
        held_next = held_reg;
        if (hold_count_reg >= divide_reg) begin
            held_next = s_sample_in;
            hc0       = '0;
        end
        hold_count_next = hc0 + RATIO_W'(1);

        bank_we    = 1'b0;
        bank_waddr = wpw[AW-1:0];
        bank_raddr = rp1[AW-1:0];
        fill_next  = fill_reg;

        p1_next.use_bank = 1'b0;
        p1_next.direct   = s_sample_in;
        p1_next.playing  = play_reg;

        case (mode_reg)
            MODE_EXPAND: begin
                bank_we          = wr;
                fill_next        = fill_new;
                p1_next.playing  = play_next;
                // same-word write is forwarded, unwritten or past-end reads are zero
                if (play1 && wr && (rp1 == wpw)) begin
                    p1_next.direct = s_sample_in;
                end else if (play1 && (rp1 < fill_new)) begin
                    p1_next.use_bank = 1'b1;
                    p1_next.direct   = '0;
                end else begin
                    p1_next.direct = '0;
                end
            end
            MODE_DIVIDE: begin
                p1_next.direct = held_next;
            end
            default: ;
        endcase
    end

    // state registers, updated on accept only for the active mode
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            write_pos_reg     <= '0;
            read_pos_reg      <= '0;
            stretch_count_reg <= '0;
            recording_reg     <= 1'b0;
            play_reg          <= 1'b0;
            hold_count_reg    <= '0;
            held_reg          <= '0;
            fill_reg          <= '0;
        end else if (s_accept) begin
            case (mode_reg)
                MODE_EXPAND: begin
                    write_pos_reg     <= write_pos_next;
                    read_pos_reg      <= read_pos_next;
                    stretch_count_reg <= stretch_count_next;
                    recording_reg     <= recording_next;
                    play_reg          <= play_next;
                    fill_reg          <= fill_next;
                end
                MODE_DIVIDE: begin
                    hold_count_reg <= hold_count_next;
                    held_reg       <= held_next;
                end
                default: ;
            endcase
        end
    end

    // sample bank, read data lands with the word in stage one
    tediv_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (BANK_DEPTH)
    ) u_bank (
        .aclk  (aclk),
        .we    (s_accept && bank_we),
        .waddr (bank_waddr),
        .wdata (s_sample_in),
        .re    (s_accept),
        .raddr (bank_raddr),
        .rdata (bank_rdata)
    );

    // stage one: waiting on the bank read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            p1_valid_reg <= s_accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            p1_reg <= p1_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && p1_valid_reg) begin
            m_sample_reg  <= p1_reg.use_bank ? bank_rdata : p1_reg.direct;
            m_playing_reg <= p1_reg.playing;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_sample_out = m_sample_reg;
    assign m_playing    = m_playing_reg;

endmodule
